// ===== rtl/mfmc_pkg.sv =====
package mfmc_pkg;

    localparam int MFMC_MAX_NODES = 64;
    localparam int CFG_W = 7;
    localparam int CAP_W = 31;
    localparam int FLOW_W = 32;
    localparam int RES_W = 33;
    localparam int TOTAL_W = 37;
    localparam int NODE_W = 6;
    localparam int MODE_W = 2;
    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_SET_EDGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    typedef enum logic [4:0] {
        ST_CLR_CAP,
        ST_IDLE,
        ST_BAD,
        ST_CLR_FLOW,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_POPW,
        ST_BFS_SCAN,
        ST_BFS_DONE,
        ST_W1_P,
        ST_W1_PW,
        ST_W1_R,
        ST_W2_P,
        ST_W2_PW,
        ST_W2_A,
        ST_W2_B,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/mfmc_ram.sv =====
module mfmc_ram
    import mfmc_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/max_flow_min_cut.sv =====
// Max flow / min cut engine (Edmonds-Karp over a capacity matrix in block RAM), one item at a time.
// Edge write and unused mode: the engine stays idle. Clear: zeroes every capacity entry.
// Bad compute: its one result item is offered the cycle after accept. Good compute: zeroes every
// flow entry, then repeats a breadth-first search and, per augmenting path, a bottleneck walk and a
// flow-update walk from sink to source, then n result items at one per cycle while m_tready.
// Reset (aresetn low, synchronous) clears control state and then zeroes every capacity entry.
module max_flow_min_cut
    import mfmc_pkg::*;
#(
    parameter int MAX_NODES = MFMC_MAX_NODES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // tail_node, head_node, edge_capacity
    input  logic [MODE_W-1:0] s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // total_flow, node_index, source_side
    output logic              m_tuser,   // bad_request
    output logic              m_tlast
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = NW + 1;
    localparam int AW = 2 * NW;
    localparam int MDEPTH = 2 ** AW;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   node_count_reg;
    logic [CW-1:0]      n_used;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      src_reg, src_next, dst_reg, dst_next;
    logic [NW-1:0]      u_reg, u_next, v_reg, v_next;
    logic [CW-1:0]      head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]      iss_reg, iss_next, i_reg, i_next;
    logic               pv_reg, pv_next;
    logic [NW-1:0]      pn_reg, pn_next;
    logic [RES_W-1:0]   neck_reg, neck_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [MAX_NODES-1:0] seen_reg, seen_next;

    logic               cap_we, flow_we, par_we, q_we;
    logic [AW-1:0]      cap_waddr, cap_raddr, flow_waddr, flow_raddr;
    logic [CAP_W-1:0]   cap_wdata, cap_rdata;
    logic [FLOW_W-1:0]  flow_wdata, flow_rdata;
    logic [NW-1:0]      par_waddr, par_raddr, par_wdata, par_rdata;
    logic [NW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;

    logic               accept;
    logic [NODE_W-1:0]  in_a, in_b;
    logic               a_ok, b_ok;
    logic [RES_W-1:0]   res;
    logic               res_pos;

    assign in_a = s_tdata[5:0];
    assign in_b = s_tdata[11:6];
    assign a_ok = CW'(in_a) < n_used;
    assign b_ok = CW'(in_b) < n_used;
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        if (node_count_reg < 7'd2) begin
            n_used = CW'(2);
        end else if (32'(node_count_reg) > MAX_NODES) begin
            n_used = CW'(MAX_NODES);
        end else begin
            n_used = CW'(node_count_reg);
        end
    end

    assign res = {2'b00, cap_rdata} - {flow_rdata[FLOW_W-1], flow_rdata};
    assign res_pos = !res[RES_W-1] && (res != '0);

    mfmc_ram #(.WIDTH(CAP_W), .DEPTH(MDEPTH)) u_cap (
        .aclk(aclk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(cap_raddr), .rdata(cap_rdata)
    );
    mfmc_ram #(.WIDTH(FLOW_W), .DEPTH(MDEPTH)) u_flow (
        .aclk(aclk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(flow_raddr), .rdata(flow_rdata)
    );
    mfmc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    mfmc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR_CAP: begin
                if (cnt_reg == AW'(MDEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == MODE_CLEAR) begin
                        state_next = ST_CLR_CAP;
                    end else if (s_tuser == MODE_COMPUTE) begin
                        if (in_a == in_b || !a_ok || !b_ok) state_next = ST_BAD;
                        else state_next = ST_CLR_FLOW;
                    end
                end
            end
            ST_BAD: begin
                if (m_tready) state_next = ST_IDLE;
            end
            ST_CLR_FLOW: begin
                if (cnt_reg == AW'(MDEPTH - 1)) state_next = ST_BFS_INIT;
            end
            ST_BFS_INIT: state_next = ST_BFS_POP;
            ST_BFS_POP: begin
                if (head_reg == tail_reg) state_next = ST_BFS_DONE;
                else state_next = ST_BFS_POPW;
            end
            ST_BFS_POPW: state_next = ST_BFS_SCAN;
            ST_BFS_SCAN: begin
                if (!(iss_reg < n_used) && !pv_reg) state_next = ST_BFS_POP;
            end
            ST_BFS_DONE: begin
                if (seen_reg[dst_reg]) state_next = ST_W1_P;
                else state_next = ST_EMIT;
            end
            ST_W1_P: begin
                if (v_reg == src_reg) state_next = ST_W2_P;
                else state_next = ST_W1_PW;
            end
            ST_W1_PW: state_next = ST_W1_R;
            ST_W1_R: state_next = ST_W1_P;
            ST_W2_P: begin
                if (v_reg == src_reg) state_next = ST_BFS_INIT;
                else state_next = ST_W2_PW;
            end
            ST_W2_PW: state_next = ST_W2_A;
            ST_W2_A: state_next = ST_W2_B;
            ST_W2_B: state_next = ST_W2_P;
            ST_EMIT: begin
                if (m_tready && (i_reg == n_used - CW'(1))) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cnt_next = cnt_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        u_next = u_reg;
        v_next = v_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        iss_next = iss_reg;
        i_next = i_reg;
        pv_next = 1'b0;
        pn_next = pn_reg;
        neck_next = neck_reg;
        total_next = total_reg;
        seen_next = seen_reg;
        cap_we = 1'b0;
        cap_waddr = cnt_reg;
        cap_wdata = '0;
        cap_raddr = {u_reg, iss_reg[NW-1:0]};
        flow_we = 1'b0;
        flow_waddr = cnt_reg;
        flow_wdata = '0;
        flow_raddr = {u_reg, iss_reg[NW-1:0]};
        par_we = 1'b0;
        par_waddr = pn_reg;
        par_wdata = u_reg;
        par_raddr = v_reg;
        q_we = 1'b0;
        q_waddr = tail_reg[NW-1:0];
        q_wdata = pn_reg;
        q_raddr = head_reg[NW-1:0];
        case (state_reg)
            ST_CLR_CAP: begin
                cap_we = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (s_tuser == MODE_SET_EDGE && a_ok && b_ok) begin
                        cap_we = 1'b1;
                        cap_waddr = {NW'(in_a), NW'(in_b)};
                        cap_wdata = s_tdata[42:12];
                    end
                    src_next = NW'(in_a);
                    dst_next = NW'(in_b);
                    total_next = '0;
                end
            end
            ST_CLR_FLOW: begin
                flow_we = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            ST_BFS_INIT: begin
                seen_next = '0;
                seen_next[src_reg] = 1'b1;
                par_we = 1'b1;
                par_waddr = src_reg;
                par_wdata = src_reg;
                q_we = 1'b1;
                q_waddr = '0;
                q_wdata = src_reg;
                head_next = '0;
                tail_next = CW'(1);
                i_next = '0;
            end
            ST_BFS_POP: begin
                head_next = head_reg + CW'(1);
            end
            ST_BFS_POPW: begin
                u_next = q_rdata;
                iss_next = '0;
            end
            ST_BFS_SCAN: begin
                if (iss_reg < n_used) begin
                    pv_next = 1'b1;
                    pn_next = iss_reg[NW-1:0];
                    iss_next = iss_reg + CW'(1);
                end
                if (pv_reg && !seen_reg[pn_reg] && res_pos) begin
                    seen_next[pn_reg] = 1'b1;
                    par_we = 1'b1;
                    q_we = 1'b1;
                    tail_next = tail_reg + CW'(1);
                end
            end
            ST_BFS_DONE: begin
                v_next = dst_reg;
                neck_next = '1;
            end
            ST_W1_PW: begin
                u_next = par_rdata;
                cap_raddr = {par_rdata, v_reg};
                flow_raddr = {par_rdata, v_reg};
            end
            ST_W1_R: begin
                if (res < neck_reg) neck_next = res;
                v_next = u_reg;
            end
            ST_W1_P: begin
                if (v_reg == src_reg) v_next = dst_reg;
            end
            ST_W2_P: begin
                if (v_reg == src_reg) total_next = total_reg + TOTAL_W'(neck_reg);
            end
            ST_W2_PW: begin
                u_next = par_rdata;
                flow_raddr = {par_rdata, v_reg};
            end
            ST_W2_A: begin
                flow_we = 1'b1;
                flow_waddr = {u_reg, v_reg};
                flow_wdata = flow_rdata + neck_reg[FLOW_W-1:0];
                flow_raddr = {v_reg, u_reg};
            end
            ST_W2_B: begin
                flow_we = 1'b1;
                flow_waddr = {v_reg, u_reg};
                flow_wdata = flow_rdata - neck_reg[FLOW_W-1:0];
                v_next = u_reg;
            end
            ST_EMIT: begin
                if (m_tready) i_next = i_reg + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_CAP;
            node_count_reg <= NODE_COUNT_RESET;
            cnt_reg <= '0;
            pv_reg <= 1'b0;
            seen_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) node_count_reg <= cfg_wdata;
            cnt_reg <= cnt_next;
            pv_reg <= pv_next;
            seen_reg <= seen_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        u_reg <= u_next;
        v_reg <= v_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        iss_reg <= iss_next;
        i_reg <= i_next;
        pn_reg <= pn_next;
        neck_reg <= neck_next;
    end

    // result outputs
    always_comb begin
        m_tvalid = 1'b0;
        m_tdata = '0;
        m_tuser = 1'b0;
        m_tlast = 1'b0;
        case (state_reg)
            ST_BAD: begin
                m_tvalid = 1'b1;
                m_tuser = 1'b1;
                m_tlast = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tdata[36:0] = total_reg;
                m_tdata[42:37] = NODE_W'(i_reg);
                m_tdata[43] = seen_reg[i_reg[NW-1:0]];
                m_tlast = (i_reg == n_used - CW'(1));
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mfmc_pkg::*;

    localparam int NN = 64;
    localparam int SETTLE = 6000;
    localparam longint CYCLE_LIMIT = 100000000;
    localparam logic [CAP_W-1:0] CAP_ALL = {CAP_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] tail;
        logic [NODE_W-1:0] head;
        logic [CAP_W-1:0]  cap;
    } edge_cmd_t;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic [NODE_W-1:0]  node;
        logic               side;
        logic               bad;
        logic               last;
    } cut_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;     // tail_node, head_node, edge_capacity
    logic [MODE_W-1:0] s_tuser = '0;     // mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;          // total_flow, node_index, source_side
    logic              m_tuser;          // bad_request
    logic              m_tlast;

    max_flow_min_cut uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    edge_cmd_t pend_q[$];
    cut_row_t  cut_q[$];
    int        errors = 0;
    int        hold_req = 0;
    int        nodes_cfg = 64;

    logic [CAP_W-1:0] cap_m [0:NN*NN-1];
    longint           flow_m [0:NN*NN-1];
    bit               seen_m [0:NN-1];
    int               parent_m [0:NN-1];

    function automatic int nodes_used();
        if (nodes_cfg < 2) return 2;
        if (nodes_cfg > NN) return NN;
        return nodes_cfg;
    endfunction

    function automatic longint resid(int u, int v);
        return longint'(cap_m[u*NN+v]) - flow_m[u*NN+v];
    endfunction

    function automatic bit bfs_reach(int n, int src, int dst);
        int fifo[NN];
        int rd;
        int wr;
        int u;
        rd = 0;
        wr = 0;
        for (int i = 0; i < NN; i++) seen_m[i] = 0;
        seen_m[src] = 1;
        parent_m[src] = src;
        fifo[wr++] = src;
        while (rd < wr) begin
            u = fifo[rd++];
            for (int v = 0; v < n; v++) begin
                if (!seen_m[v] && resid(u, v) > 0) begin
                    seen_m[v] = 1;
                    parent_m[v] = u;
                    if (wr < NN) fifo[wr++] = v;
                end
            end
        end
        return seen_m[dst];
    endfunction

    task automatic predict_cut(edge_cmd_t c);
        int n;
        int a;
        int b;
        int v;
        int u;
        int steps;
        longint neck;
        logic [TOTAL_W-1:0] total;
        cut_row_t row;
        n = nodes_used();
        a = c.tail;
        b = c.head;
        if (c.mode == MODE_SET_EDGE) begin
            if (a < n && b < n) cap_m[a*NN+b] = c.cap;
        end else if (c.mode == MODE_CLEAR) begin
            for (int k = 0; k < NN*NN; k++) cap_m[k] = '0;
        end else if (c.mode == MODE_COMPUTE) begin
            if (a == b || a >= n || b >= n) begin
                row = '{total: '0, node: '0, side: 1'b0, bad: 1'b1, last: 1'b1};
                cut_q.insert(cut_q.size(), row);
            end else begin
                for (int k = 0; k < NN*NN; k++) flow_m[k] = 0;
                total = '0;
                while (bfs_reach(n, a, b)) begin
                    neck = 64'h7FFF_FFFF_FFFF_FFFF;
                    v = b;
                    steps = 0;
                    while (v != a && steps < n) begin
                        u = parent_m[v];
                        if (resid(u, v) < neck) neck = resid(u, v);
                        v = u;
                        steps++;
                    end
                    v = b;
                    steps = 0;
                    while (v != a && steps < n) begin
                        u = parent_m[v];
                        flow_m[u*NN+v] += neck;
                        flow_m[v*NN+u] -= neck;
                        v = u;
                        steps++;
                    end
                    total = total + neck[TOTAL_W-1:0];
                end
                for (int i = 0; i < n; i++) begin
                    row = '{total: total, node: i[NODE_W-1:0], side: seen_m[i],
                            bad: 1'b0, last: (i == n-1)};
                    cut_q.insert(cut_q.size(), row);
                end
            end
        end
    endtask

    // sender
    int burst_left = 0;
    int gap_left = 0;
    edge_cmd_t cur;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_cut(cur);
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                cur = pend_q.pop_front();
                s_tdata <= {5'd0, cur.cap, cur.head, cur.tail};
                s_tuser <= cur.mode;
                s_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    int hold_seen = 0;
    int hold_left = 0;
    int ready_mode = 0;
    int ready_ctr = 0;

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 12000;
        end
        if (ready_ctr == 0) begin
            ready_ctr = $urandom_range(20, 300);
            ready_mode = $urandom_range(0, 2);
        end
        ready_ctr--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // checker
    cut_row_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cut_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: tdata=%h tuser=%b tlast=%b",
                                           m_tdata, m_tuser, m_tlast);
            end else begin
                want = cut_q.pop_front();
                if (m_tdata[36:0] !== want.total || m_tdata[42:37] !== want.node ||
                    m_tdata[43] !== want.side || m_tuser !== want.bad ||
                    m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("mismatch: exp flow=%0d node=%0d side=%b bad=%b last=%b",
                               want.total, want.node, want.side, want.bad, want.last);
                        $display(" | got flow=%0d node=%0d side=%b bad=%b last=%b",
                                 m_tdata[36:0], m_tdata[42:37], m_tdata[43], m_tuser,
                                 m_tlast);
                    end
                end
            end
        end
    end

    longint cyc = 0;

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add(int mode, int t, int h, logic [CAP_W-1:0] c);
        edge_cmd_t e;
        e.mode = mode[MODE_W-1:0];
        e.tail = t[NODE_W-1:0];
        e.head = h[NODE_W-1:0];
        e.cap = c;
        pend_q.insert(pend_q.size(), e);
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_tvalid || cut_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_nodes(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        nodes_cfg = v & 7'h7F;
    endtask

    function automatic logic [CAP_W-1:0] rand_cap();
        case ($urandom_range(0, 5))
            0: return CAP_ALL;
            1, 2: return $urandom() & CAP_ALL;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    function automatic int pick_node(int n);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n-1);
    endfunction

    int made = 0;

    task automatic gen_seq(int n, int max_edges);
        int k;
        int s;
        int d;
        if ($urandom_range(0, 4) == 0) begin
            add($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom() & CAP_ALL);
            made++;
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            add(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), rand_cap());
            made++;
        end
        k = $urandom_range(1, max_edges);
        for (int i = 0; i < k; i++) begin
            add(MODE_SET_EDGE, pick_node(n), pick_node(n), rand_cap());
            made++;
        end
        for (int i = $urandom_range(1, 2); i > 0; i--) begin
            s = pick_node(n);
            d = ($urandom_range(0, 7) == 0) ? s : pick_node(n);
            add(MODE_COMPUTE, s, d, rand_cap());
            made++;
        end
    endtask

    int phase_nodes[11] = '{12, 2, 5, 64, 8, 0, 3, 127, 16, 1, 6};
    int pn;

    initial begin
        for (int k = 0; k < NN*NN; k++) cap_m[k] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        add(MODE_COMPUTE, 0, 63, '0);
        add(MODE_SET_EDGE, 0, 1, CAP_ALL);
        add(MODE_SET_EDGE, 1, 63, CAP_ALL);
        add(MODE_SET_EDGE, 0, 2, 5);
        add(MODE_SET_EDGE, 2, 63, 3);
        add(MODE_SET_EDGE, 0, 3, CAP_ALL);
        add(MODE_SET_EDGE, 3, 63, 31'h2AAA_AAAA);
        add(MODE_SET_EDGE, 5, 5, 100);
        add(MODE_SET_EDGE, 63, 0, 1);
        add(MODE_SET_EDGE, 1, 2, 0);
        add(3, 63, 63, CAP_ALL);
        add(MODE_COMPUTE, 0, 63, '0);
        add(MODE_COMPUTE, 3, 3, CAP_ALL);
        add(MODE_COMPUTE, 63, 0, '0);
        add(MODE_SET_EDGE, 1, 2, 7);
        add(MODE_SET_EDGE, 2, 1, 7);
        add(MODE_SET_EDGE, 1, 3, 1);
        add(MODE_COMPUTE, 0, 63, '0);
        add(MODE_CLEAR, 63, 63, CAP_ALL);
        add(MODE_COMPUTE, 0, 63, '0);
        add(MODE_SET_EDGE, 62, 61, 9);
        add(MODE_COMPUTE, 62, 61, '0);

        pn = 0;
        while (made < 470) begin
            set_nodes(phase_nodes[pn % 11]);
            if (pn == 0) begin
                for (int i = 0; i < 8 && made < 470; i++) gen_seq(12, 10);
                hold_req++;
            end else if (phase_nodes[pn % 11] >= NN) begin
                for (int i = 0; i < 2 && made < 470; i++) gen_seq(NN, 10);
            end else begin
                for (int i = 0; i < 8 && made < 470; i++)
                    gen_seq(nodes_used(), 3 * nodes_used());
            end
            pn++;
        end

        drain();
        if (errors == 0 && cut_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
